// ===== design/idx_list_pkg.sv =====
// Shared types and constants for the indexed insert/remove list.
// Holds the command codes, status codes and the per-cell control word.
// No dependencies.
package idx_list_pkg;

  // Width of positions and counts inside the cell row (covers DEPTH up to 127)
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;

  // Input command codes (carried on in_tuser)
  typedef enum logic [2:0] {
    CMD_INSERT      = 3'd0,
    CMD_APPEND      = 3'd1,
    CMD_REMOVE      = 3'd2,
    CMD_REMOVE_LAST = 3'd3,
    CMD_CLEAR       = 3'd4,
    CMD_LIST        = 3'd5
  } cmd_t;

  // Result status codes (carried on out_tuser)
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_INS  = 3'd1,
    OP_WR   = 3'd2,
    OP_DEL  = 3'd3,
    OP_ROT  = 3'd4
  } cell_op_t;

  // Control word shared by the whole row
  typedef struct packed {
    cell_op_t            op;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    cnt;
    logic [POS_W-1:0]    rd_idx;
    logic [WORD_W-1:0]   data;
  } cell_ctrl_t;

endpackage

// ===== design/indexed_insert_remove_list_core.sv =====
// Top level of the indexed insert/remove list: control, result register and cell row.
// Depends on idx_list_pkg and idx_list_cell.
//
// Usage:
//   Commands enter on the in_ stream (command on in_tuser, position and data word
//   on in_tdata). Results leave on the out_ stream (status on out_tuser, word and
//   entry count on out_tdata, out_tlast on the final result of a command).
//   Insert, append, remove, remove-last and clear each give one result; the row
//   of cells moves or writes all affected words at once, so such a command's result
//   is registered at the accepting edge and offered in the cycle after acceptance.
//   List gives one result per stored entry (one result with status empty when
//   the list is empty): the command moves the control into the list state, and
//   each step there rotates the row by one place and registers one result while
//   the output is free, so the input is held until the walk ends and the row is
//   back in order afterwards.
//   Throughput: one command per cycle while the output is not stalled.
//   in_tready is low while a list is being walked and while a result waits in
//   the output register with out_tready low; a stalled receiver holds the block.
//   Reset (rst_n low, synchronous) empties the list and drops any pending result;
//   stored words are not cleared and are never read beyond the count.
module indexed_insert_remove_list_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] position, [36:5] data_word, [39:37] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] out_word, [36:32] entry_count, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = idx_list_pkg::POS_W;
  localparam int WW = idx_list_pkg::WORD_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   list_idx_r, list_idx_nxt;

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [WW-1:0]   out_word_r;
  logic [4:0]      out_cnt_r;
  logic            out_last_r;

  logic            out_free;
  logic            acc;
  logic            load;
  logic [1:0]      res_status;
  logic [WW-1:0]   res_word;
  logic            res_last;

  idx_list_pkg::cell_ctrl_t ctrl;

  logic [WW-1:0]   cell_word [DEPTH];
  logic [WW-1:0]   cell_tap  [DEPTH];
  logic [WW-1:0]   tap_bus;

  logic [4:0]      in_pos;
  logic [WW-1:0]   in_word;
  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   cnt_ext;
  logic [PW-1:0]   cnt_m1;

  assign in_pos  = in_tdata[4:0];
  assign in_word = in_tdata[36:5];
  assign pos_ext = PW'(in_pos);
  assign cnt_ext = PW'(count_r);
  assign cnt_m1  = cnt_ext - PW'(1);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  // read bus: OR of the cell taps, only the addressed cell is non-zero
  always_comb begin
    tap_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_bus = tap_bus | cell_tap[i];
    end
  end

  // command decode and list walk
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    list_idx_nxt = list_idx_r;
    load         = 1'b0;
    res_status   = idx_list_pkg::STAT_OK;
    res_word     = '0;
    res_last     = 1'b1;
    ctrl.op      = idx_list_pkg::OP_HOLD;
    ctrl.pos     = pos_ext;
    ctrl.cnt     = cnt_ext;
    ctrl.rd_idx  = pos_ext;
    ctrl.data    = in_word;

    if (state_r == S_LIST) begin
      if (out_free) begin
        load     = 1'b1;
        ctrl.op  = idx_list_pkg::OP_ROT;
        res_word = cell_word[0];
        res_last = (list_idx_r == count_r - CW'(1));
        list_idx_nxt = list_idx_r + CW'(1);
        if (res_last) begin
          state_nxt = S_IDLE;
        end
      end
    end else if (acc) begin
      load = 1'b1;
      unique case (idx_list_pkg::cmd_t'(in_tuser))
        idx_list_pkg::CMD_INSERT: begin
          if (pos_ext > cnt_ext) begin
            res_status = idx_list_pkg::STAT_BADPOS;
          end else if (count_r == CNT_FULL) begin
            res_status = idx_list_pkg::STAT_FULL;
          end else begin
            ctrl.op   = idx_list_pkg::OP_INS;
            count_nxt = count_r + CW'(1);
          end
        end
        idx_list_pkg::CMD_APPEND: begin
          if (count_r == CNT_FULL) begin
            res_status = idx_list_pkg::STAT_FULL;
          end else begin
            ctrl.op   = idx_list_pkg::OP_WR;
            count_nxt = count_r + CW'(1);
          end
        end
        idx_list_pkg::CMD_REMOVE: begin
          if (pos_ext >= cnt_ext) begin
            res_status = idx_list_pkg::STAT_BADPOS;
          end else begin
            ctrl.op   = idx_list_pkg::OP_DEL;
            res_word  = tap_bus;
            count_nxt = count_r - CW'(1);
          end
        end
        idx_list_pkg::CMD_REMOVE_LAST: begin
          if (count_r == '0) begin
            res_status = idx_list_pkg::STAT_EMPTY;
          end else begin
            ctrl.rd_idx = cnt_m1;
            res_word    = tap_bus;
            count_nxt   = count_r - CW'(1);
          end
        end
        idx_list_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        idx_list_pkg::CMD_LIST: begin
          if (count_r == '0) begin
            res_status = idx_list_pkg::STAT_EMPTY;
          end else begin
            // results come from the walk that starts next cycle
            load         = 1'b0;
            list_idx_nxt = '0;
            state_nxt    = S_LIST;
          end
        end
        default: begin
          res_status = idx_list_pkg::STAT_OK;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      list_idx_r <= list_idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_word_r   <= res_word;
      out_cnt_r    <= 5'(count_nxt);
      out_last_r   <= res_last;
    end
  end

  // row of storage cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WW-1:0] left_w;
    logic [WW-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    idx_list_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (cell_word[0]),
      .word_o     (cell_word[g]),
      .tap_o      (cell_tap[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_word_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/idx_list_cell.sv =====
// One storage cell of the list row: holds a single data word.
// Takes its next word from itself, its neighbours, the head cell or the input.
// Depends on idx_list_pkg.
module idx_list_cell #(
  parameter int IDX = 0
) (
  input  logic                                 clk,
  input  idx_list_pkg::cell_ctrl_t             ctrl,
  input  logic [idx_list_pkg::WORD_W-1:0]      left_word,
  input  logic [idx_list_pkg::WORD_W-1:0]      right_word,
  input  logic [idx_list_pkg::WORD_W-1:0]      head_word,
  output logic [idx_list_pkg::WORD_W-1:0]      word_o,
  output logic [idx_list_pkg::WORD_W-1:0]      tap_o
);

  localparam logic [idx_list_pkg::POS_W-1:0] MY_IDX  = idx_list_pkg::POS_W'(IDX);
  localparam logic [idx_list_pkg::POS_W-1:0] MY_IDX1 = idx_list_pkg::POS_W'(IDX + 1);

  logic [idx_list_pkg::WORD_W-1:0] word_r;
  logic [idx_list_pkg::WORD_W-1:0] word_nxt;

  // next word for this place in the row
  always_comb begin
    word_nxt = word_r;
    case (ctrl.op)
      idx_list_pkg::OP_INS: begin
        if (MY_IDX > ctrl.pos) begin
          word_nxt = left_word;
        end else if (MY_IDX == ctrl.pos) begin
          word_nxt = ctrl.data;
        end
      end
      idx_list_pkg::OP_WR: begin
        if (MY_IDX == ctrl.cnt) begin
          word_nxt = ctrl.data;
        end
      end
      idx_list_pkg::OP_DEL: begin
        if (MY_IDX >= ctrl.pos) begin
          word_nxt = right_word;
        end
      end
      idx_list_pkg::OP_ROT: begin
        // rotate the valid part of the row down by one place
        if (MY_IDX1 < ctrl.cnt) begin
          word_nxt = right_word;
        end else if (MY_IDX1 == ctrl.cnt) begin
          word_nxt = head_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;
  // selected cell drives the read bus, others give zero
  assign tap_o  = (MY_IDX == ctrl.rd_idx) ? word_r : '0;

endmodule
